// ===== rtl/core/outcode_line_clipper_top_defines.svh =====
// Assertion macros for the outcode line clipper.
`ifndef OUTCODE_LINE_CLIPPER_TOP_DEFINES_SVH
`define OUTCODE_LINE_CLIPPER_TOP_DEFINES_SVH
`define OLC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("%m: label failed");
`define OLC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("%m: label failed");
`endif

// ===== rtl/core/olc_pkg.sv =====
// Shared types and constants for the outcode line clipper.
package olc_pkg;
  localparam int CoordWidth = 32;
  localparam int MaxPasses = 5;
  localparam int NumRegs = 8;
  localparam int RegIdxWidth = 3;

  localparam logic [RegIdxWidth-1:0] RegClipMinU = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegClipMaxU = 3'd1;
  localparam logic [RegIdxWidth-1:0] RegClipMinV = 3'd2;
  localparam logic [RegIdxWidth-1:0] RegClipMaxV = 3'd3;
  localparam logic [RegIdxWidth-1:0] RegTestMinU = 3'd4;
  localparam logic [RegIdxWidth-1:0] RegTestMaxU = 3'd5;
  localparam logic [RegIdxWidth-1:0] RegTestMinV = 3'd6;
  localparam logic [RegIdxWidth-1:0] RegTestMaxV = 3'd7;

  localparam int OcLeft = 0;
  localparam int OcBelow = 1;
  localparam int OcRight = 2;
  localparam int OcAbove = 3;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EVAL,
    BK_MUL,
    BK_DIV,
    BK_APPLY,
    BK_DONE
  } bk_state_t;
endpackage

// ===== rtl/core/olc_front.sv =====
// Front end: computes the end-point outcode and pushes classified segments into a queue.
module olc_front #(
  parameter int COORD_WIDTH = olc_pkg::CoordWidth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_x1,
  input  logic signed [COORD_WIDTH-1:0] in_y1,
  input  logic signed [COORD_WIDTH-1:0] in_x2,
  input  logic signed [COORD_WIDTH-1:0] in_y2,
  input  logic signed [COORD_WIDTH-1:0] t_min_u,
  input  logic signed [COORD_WIDTH-1:0] t_max_u,
  input  logic signed [COORD_WIDTH-1:0] t_min_v,
  input  logic signed [COORD_WIDTH-1:0] t_max_v,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic signed [COORD_WIDTH-1:0] q_x1,
  output logic signed [COORD_WIDTH-1:0] q_y1,
  output logic signed [COORD_WIDTH-1:0] q_x2,
  output logic signed [COORD_WIDTH-1:0] q_y2,
  output logic [3:0]                    q_c2
);
  localparam int Depth = 2;
  localparam int PW = 4 * COORD_WIDTH + 4;

  logic [PW-1:0] mem_r [Depth];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic [3:0]    c2;
  logic          push, pop;

  always_comb begin
    c2 = 4'd0;
    c2[olc_pkg::OcLeft]  = in_x2 < t_min_u;
    c2[olc_pkg::OcBelow] = in_y2 < t_min_v;
    c2[olc_pkg::OcRight] = in_x2 > t_max_u;
    c2[olc_pkg::OcAbove] = in_y2 > t_max_v;
  end

  assign in_ready = cnt_r != 2'(Depth);
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != 2'd0;
  assign pop = q_valid && q_ready;
  assign {q_x1, q_y1, q_x2, q_y2, q_c2} = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= {in_x1, in_y1, in_x2, in_y2, c2};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== rtl/core/olc_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module olc_div #(
  parameter int NW = 64,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   sh;
  logic          ge;

  assign sh = {rem_r, q_r[NW-1]};
  assign ge = sh >= {1'b0, d_r};
  assign busy = cnt_r != '0;
  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      rem_r <= '0;
      d_r <= den;
    end else if (busy) begin
      rem_r <= ge ? DW'(sh - {1'b0, d_r}) : sh[DW-1:0];
      q_r <= {q_r[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NW);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// ===== rtl/core/olc_back.sv =====
// Back end: runs clip passes on one segment and holds the result.
`include "outcode_line_clipper_top_defines.svh"
module olc_back #(
  parameter int COORD_WIDTH = olc_pkg::CoordWidth,
  parameter int MAX_PASSES  = olc_pkg::MaxPasses
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic signed [COORD_WIDTH-1:0] q_x1,
  input  logic signed [COORD_WIDTH-1:0] q_y1,
  input  logic signed [COORD_WIDTH-1:0] q_x2,
  input  logic signed [COORD_WIDTH-1:0] q_y2,
  input  logic [3:0]                    q_c2,
  input  logic signed [COORD_WIDTH-1:0] regs [olc_pkg::NumRegs],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x1,
  output logic signed [COORD_WIDTH-1:0] out_y1,
  output logic signed [COORD_WIDTH-1:0] out_x2,
  output logic signed [COORD_WIDTH-1:0] out_y2,
  output logic                          out_vis
);
  localparam int W = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int NW = 64;
  localparam int PC = $clog2(MAX_PASSES + 1);
  localparam logic signed [W+1:0] SatMax = (W+2)'((64'sd1 <<< (W - 1)) - 1);
  localparam logic signed [W+1:0] SatMin = -SatMax - 1;
  localparam logic [NW-1:0] QLim = NW'(65'd1 << W);

  olc_pkg::bk_state_t st_r, st_nxt;
  logic signed [W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [3:0]          c1_r, c2_r;
  logic                sw_r, vis_r, ov_r;
  logic [PC-1:0]       pass_r;
  logic [DW-1:0]       ma_r, mb_r, md_r;
  logic                neg_r, zero_r, ymove_r;
  logic signed [W-1:0] edge_r;
  logic [PW-1:0]       prod;
  logic                dstart, dbusy;
  logic [NW-1:0]       dquo;

  logic [3:0]          c1n;
  logic                ins, outs, swp;
  logic signed [W-1:0] px1, py1, px2, py2;
  logic [3:0]          pc1, pc2;
  logic signed [W:0]   da, db, dd;
  logic [NW-1:0]       num, q;
  logic signed [W+1:0] base, sum, satv;

  function automatic logic [3:0] ocode(input logic signed [W-1:0] x, y,
                                       input logic signed [W-1:0] mnu, mxu, mnv, mxv);
    logic [3:0] c;
    c = 4'd0;
    c[olc_pkg::OcLeft] = x < mnu;
    c[olc_pkg::OcBelow] = y < mnv;
    c[olc_pkg::OcRight] = x > mxu;
    c[olc_pkg::OcAbove] = y > mxv;
    return c;
  endfunction

  function automatic logic [DW-1:0] mg(input logic signed [W:0] v);
    return v[W] ? DW'(-v) : DW'(v);
  endfunction

  assign ins = (c1_r | c2_r) == 4'd0;
  assign outs = (c1_r & c2_r) != 4'd0;
  assign swp = c1_r == 4'd0;
  assign px1 = swp ? x2_r : x1_r;
  assign py1 = swp ? y2_r : y1_r;
  assign px2 = swp ? x1_r : x2_r;
  assign py2 = swp ? y1_r : y2_r;
  assign pc1 = swp ? c2_r : c1_r;
  assign pc2 = swp ? c1_r : c2_r;

  always_comb begin
    logic signed [W-1:0] e;
    e = regs[olc_pkg::RegClipMaxV];
    if (pc1[olc_pkg::OcLeft]) e = regs[olc_pkg::RegClipMinU];
    else if (pc1[olc_pkg::OcBelow]) e = regs[olc_pkg::RegClipMinV];
    else if (pc1[olc_pkg::OcRight]) e = regs[olc_pkg::RegClipMaxU];
    if (pc1[olc_pkg::OcLeft] || (!pc1[olc_pkg::OcBelow] && pc1[olc_pkg::OcRight])) begin
      da = (W+1)'(py2) - (W+1)'(py1);
      db = (W+1)'(e) - (W+1)'(px1);
      dd = (W+1)'(px2) - (W+1)'(px1);
    end else begin
      da = (W+1)'(px2) - (W+1)'(px1);
      db = (W+1)'(e) - (W+1)'(py1);
      dd = (W+1)'(py2) - (W+1)'(py1);
    end
  end

  assign prod = ma_r * mb_r;
  assign num = (PW > NW && prod[PW-1:NW] != '0) ? '1 : NW'(prod);
  assign dstart = st_r == olc_pkg::BK_MUL;
  assign q = zero_r ? '0 : ((dquo > QLim) ? QLim : dquo);
  assign base = ymove_r ? (W+2)'(y1_r) : (W+2)'(x1_r);
  assign sum = neg_r ? base - (W+2)'(q) : base + (W+2)'(q);
  assign satv = sum > SatMax ? SatMax : (sum < SatMin ? SatMin : sum);
  assign c1n = ymove_r
    ? ocode(edge_r, W'(satv), regs[olc_pkg::RegTestMinU], regs[olc_pkg::RegTestMaxU],
            regs[olc_pkg::RegTestMinV], regs[olc_pkg::RegTestMaxV])
    : ocode(W'(satv), edge_r, regs[olc_pkg::RegTestMinU], regs[olc_pkg::RegTestMaxU],
            regs[olc_pkg::RegTestMinV], regs[olc_pkg::RegTestMaxV]);

  olc_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(num), .den(md_r),
    .busy(dbusy), .quo(dquo)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      olc_pkg::BK_IDLE:  if (q_valid) st_nxt = olc_pkg::BK_EVAL;
      olc_pkg::BK_EVAL:  st_nxt = (ins || outs || pass_r == PC'(MAX_PASSES))
                                  ? olc_pkg::BK_DONE : olc_pkg::BK_MUL;
      olc_pkg::BK_MUL:   st_nxt = olc_pkg::BK_DIV;
      olc_pkg::BK_DIV:   if (!dbusy) st_nxt = olc_pkg::BK_APPLY;
      olc_pkg::BK_APPLY: st_nxt = olc_pkg::BK_EVAL;
      olc_pkg::BK_DONE:  if (!ov_r || out_ready) st_nxt = olc_pkg::BK_IDLE;
      default:           st_nxt = olc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready = st_r == olc_pkg::BK_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= olc_pkg::BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      olc_pkg::BK_IDLE: begin
        x1_r <= q_x1;
        y1_r <= q_y1;
        x2_r <= q_x2;
        y2_r <= q_y2;
        c2_r <= q_c2;
        c1_r <= ocode(q_x1, q_y1, regs[olc_pkg::RegTestMinU],
                      regs[olc_pkg::RegTestMaxU], regs[olc_pkg::RegTestMinV],
                      regs[olc_pkg::RegTestMaxV]);
        sw_r <= 1'b0;
        pass_r <= '0;
      end
      olc_pkg::BK_EVAL: begin
        if (!(ins || outs || pass_r == PC'(MAX_PASSES))) begin
          x1_r <= px1;
          y1_r <= py1;
          x2_r <= px2;
          y2_r <= py2;
          c1_r <= pc1;
          c2_r <= pc2;
          sw_r <= sw_r ^ swp;
          ma_r <= mg(da);
          mb_r <= mg(db);
          md_r <= mg(dd);
          neg_r <= (da[W] ^ db[W]) ^ dd[W];
          zero_r <= dd == '0;
          ymove_r <= pc1[olc_pkg::OcLeft] ||
                     (!pc1[olc_pkg::OcBelow] && pc1[olc_pkg::OcRight]);
          edge_r <= W'(db + (pc1[olc_pkg::OcLeft] ||
                     (!pc1[olc_pkg::OcBelow] && pc1[olc_pkg::OcRight])
                     ? (W+1)'(px1) : (W+1)'(py1)));
        end
      end
      olc_pkg::BK_APPLY: begin
        if (ymove_r) begin
          x1_r <= edge_r;
          y1_r <= W'(satv);
        end else begin
          x1_r <= W'(satv);
          y1_r <= edge_r;
        end
        c1_r <= c1n;
        pass_r <= pass_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (st_r == olc_pkg::BK_DONE && (!ov_r || out_ready)) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == olc_pkg::BK_DONE && (!ov_r || out_ready)) begin
      out_x1 <= sw_r ? x2_r : x1_r;
      out_y1 <= sw_r ? y2_r : y1_r;
      out_x2 <= sw_r ? x1_r : x2_r;
      out_y2 <= sw_r ? y1_r : y2_r;
      vis_r <= ins;
    end
  end

  assign out_valid = ov_r;
  assign out_vis = vis_r;

  `OLC_ASSERT_IMP(a_pass_bound, clk, rst_n, st_r == olc_pkg::BK_MUL, pass_r < PC'(MAX_PASSES))
  `OLC_ASSERT_NXT(a_mul_div, clk, rst_n, st_r == olc_pkg::BK_MUL, dbusy)
  `OLC_ASSERT_IMP(a_pop_idle, clk, rst_n, q_ready, st_r == olc_pkg::BK_IDLE)
  `OLC_ASSERT_NXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_x1))
endmodule

// ===== rtl/core/outcode_line_clipper_top.sv =====
// Outcode line clipper top level: registers, front end, queue and clip engine.
// A segment waits in the front-end queue until the idle clip engine takes it. The
// engine uses its evaluate and done states for a segment trivially inside or
// outside; each clip pass adds one 33x33 multiply, a serial divide of the product
// saturated to 64 bits and an apply step, up to MAX_PASSES passes. A two-entry
// queue decouples classification from clipping, and the result register frees
// the engine.
module outcode_line_clipper_top #(
  parameter int COORD_WIDTH = olc_pkg::CoordWidth,
  parameter int MAX_PASSES  = olc_pkg::MaxPasses
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_WIDTH-1:0]      in_start_x,
  input  logic signed [COORD_WIDTH-1:0]      in_start_y,
  input  logic signed [COORD_WIDTH-1:0]      in_end_x,
  input  logic signed [COORD_WIDTH-1:0]      in_end_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_clipped_start_x,
  output logic signed [COORD_WIDTH-1:0]      out_clipped_start_y,
  output logic signed [COORD_WIDTH-1:0]      out_clipped_end_x,
  output logic signed [COORD_WIDTH-1:0]      out_clipped_end_y,
  output logic                               out_visible,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [olc_pkg::RegIdxWidth-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]             cfg_data
);
  localparam logic signed [COORD_WIDTH-1:0] Neg = -COORD_WIDTH'(6553600);
  localparam logic signed [COORD_WIDTH-1:0] Pos = COORD_WIDTH'(6553600);

  logic signed [COORD_WIDTH-1:0] regs_r [olc_pkg::NumRegs];
  logic                          q_valid, q_ready;
  logic signed [COORD_WIDTH-1:0] q_x1, q_y1, q_x2, q_y2;
  logic [3:0]                    q_c2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < olc_pkg::NumRegs; i++) begin
        regs_r[i] <= i[0] ? Pos : Neg;
      end
    end else if (cfg_valid) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  olc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_x1(in_start_x), .in_y1(in_start_y), .in_x2(in_end_x), .in_y2(in_end_y),
    .t_min_u(regs_r[olc_pkg::RegTestMinU]), .t_max_u(regs_r[olc_pkg::RegTestMaxU]),
    .t_min_v(regs_r[olc_pkg::RegTestMinV]), .t_max_v(regs_r[olc_pkg::RegTestMaxV]),
    .q_valid(q_valid), .q_ready(q_ready), .q_x1(q_x1), .q_y1(q_y1),
    .q_x2(q_x2), .q_y2(q_y2), .q_c2(q_c2)
  );

  olc_back #(.COORD_WIDTH(COORD_WIDTH), .MAX_PASSES(MAX_PASSES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_x1(q_x1), .q_y1(q_y1), .q_x2(q_x2), .q_y2(q_y2), .q_c2(q_c2),
    .regs(regs_r), .out_valid(out_valid), .out_ready(out_ready),
    .out_x1(out_clipped_start_x), .out_y1(out_clipped_start_y),
    .out_x2(out_clipped_end_x), .out_y2(out_clipped_end_y), .out_vis(out_visible)
  );
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the outcode line clipper top level.
module tb_top;
  import olc_pkg::*;

  localparam int W = CoordWidth;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct {
    logic signed [W-1:0] sx, sy, ex, ey;
    logic vis;
  } segment_t;

  class clip_scoreboard;
    logic signed [W-1:0] bounds [NumRegs];
    segment_t pending[$];
    int errors;

    function void init_bounds();
      bounds[RegClipMinU] = -6553600; bounds[RegClipMaxU] = 6553600;
      bounds[RegClipMinV] = -6553600; bounds[RegClipMaxV] = 6553600;
      bounds[RegTestMinU] = -6553600; bounds[RegTestMaxU] = 6553600;
      bounds[RegTestMinV] = -6553600; bounds[RegTestMaxV] = 6553600;
      errors = 0;
    endfunction

    function logic [3:0] region(longint x, longint y);
      logic [3:0] c;
      c = '0;
      c[OcLeft]  = x < longint'(bounds[RegTestMinU]);
      c[OcBelow] = y < longint'(bounds[RegTestMinV]);
      c[OcRight] = x > longint'(bounds[RegTestMaxU]);
      c[OcAbove] = y > longint'(bounds[RegTestMaxV]);
      return c;
    endfunction

    function longint ratio(longint a, longint b, longint d);
      logic [63:0] ua, ub, q;
      logic [127:0] p;
      bit neg;
      if (d == 0) return 0;
      neg = ((a < 0) != (b < 0)) != (d < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = ua * ub;
      if (p[127:64] != 0) p = {64'd0, {64{1'b1}}};
      q = p[63:0] / (d < 0 ? -d : d);
      if (q > 64'd1 << W) q = 64'd1 << W;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function longint clamp(longint v);
      if (v > longint'(CMAX)) return CMAX;
      if (v < longint'(CMIN)) return CMIN;
      return v;
    endfunction

    function void note_segment(segment_t s);
      longint x1, y1, x2, y2, t;
      logic [3:0] c1, c2, tc;
      bit in_box, outside, swapped;
      int pass;
      segment_t r;
      x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
      c1 = region(x1, y1); c2 = region(x2, y2);
      in_box = (c1 | c2) == 0; outside = (c1 & c2) != 0;
      swapped = 0; pass = 0;
      while (!outside && !in_box && pass < MaxPasses) begin
        if (c1 == 0) begin
          t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t;
          tc = c1; c1 = c2; c2 = tc; swapped = !swapped;
        end
        if (c1[OcLeft]) begin
          y1 = clamp(y1 + ratio(y2 - y1, longint'(bounds[RegClipMinU]) - x1, x2 - x1));
          x1 = bounds[RegClipMinU];
        end else if (c1[OcBelow]) begin
          x1 = clamp(x1 + ratio(x2 - x1, longint'(bounds[RegClipMinV]) - y1, y2 - y1));
          y1 = bounds[RegClipMinV];
        end else if (c1[OcRight]) begin
          y1 = clamp(y1 + ratio(y2 - y1, longint'(bounds[RegClipMaxU]) - x1, x2 - x1));
          x1 = bounds[RegClipMaxU];
        end else if (c1[OcAbove]) begin
          x1 = clamp(x1 + ratio(x2 - x1, longint'(bounds[RegClipMaxV]) - y1, y2 - y1));
          y1 = bounds[RegClipMaxV];
        end
        c1 = region(x1, y1);
        in_box = (c1 | c2) == 0; outside = (c1 & c2) != 0;
        pass++;
      end
      if (swapped) begin
        t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t;
      end
      r.sx = x1[W-1:0]; r.sy = y1[W-1:0]; r.ex = x2[W-1:0]; r.ey = y2[W-1:0];
      r.vis = in_box;
      pending.push_back(r);
    endfunction

    function void check_result(segment_t a);
      segment_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d %0d %0b", $time,
                 a.sx, a.sy, a.ex, a.ey, a.vis);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.sx !== e.sx) begin
        $display("%0t: start_x expected %0d actual %0d", $time, e.sx, a.sx); errors++;
      end
      if (a.sy !== e.sy) begin
        $display("%0t: start_y expected %0d actual %0d", $time, e.sy, a.sy); errors++;
      end
      if (a.ex !== e.ex) begin
        $display("%0t: end_x expected %0d actual %0d", $time, e.ex, a.ex); errors++;
      end
      if (a.ey !== e.ey) begin
        $display("%0t: end_y expected %0d actual %0d", $time, e.ey, a.ey); errors++;
      end
      if (a.vis !== e.vis) begin
        $display("%0t: visible expected %0b actual %0b", $time, e.vis, a.vis); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [W-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] out_clipped_start_x, out_clipped_start_y;
  logic signed [W-1:0] out_clipped_end_x, out_clipped_end_y;
  logic out_visible;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RegIdxWidth-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;
  int out_wait;

  clip_scoreboard sb;

  outcode_line_clipper_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [W-1:0] rand_coord(int scale);
    case ($urandom_range(0, 9))
      0: return CMAX;
      1: return CMIN;
      2: return $urandom();
      default: return $signed($urandom_range(0, 2 * scale)) - scale;
    endcase
  endfunction

  task automatic write_reg(logic [RegIdxWidth-1:0] idx, logic signed [W-1:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.bounds[idx] = val;
  endtask

  task automatic set_window(logic signed [W-1:0] cl, cr, cb, ct, int widen);
    write_reg(RegClipMinU, cl); write_reg(RegClipMaxU, cr);
    write_reg(RegClipMinV, cb); write_reg(RegClipMaxV, ct);
    write_reg(RegTestMinU, cl - widen); write_reg(RegTestMaxU, cr + widen);
    write_reg(RegTestMinV, cb - widen); write_reg(RegTestMaxV, ct + widen);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_segment(logic signed [W-1:0] sx, sy, ex, ey, bit gaps);
    segment_t s;
    int idle;
    idle = gaps ? $urandom_range(0, 6) : 0;
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= sx; in_start_y <= sy; in_end_x <= ex; in_end_y <= ey;
    s.sx = sx; s.sy = sy; s.ex = ex; s.ey = ey; s.vis = 0;
    do @(posedge clk); while (!in_ready);
    sb.note_segment(s);
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 20000) begin
      @(posedge clk); guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic random_phase(int n, int scale, bit gaps);
    repeat (n)
      send_segment(rand_coord(scale), rand_coord(scale), rand_coord(scale),
                   rand_coord(scale), gaps);
  endtask

  always @(posedge clk) begin
    segment_t a;
    if (!rst_n) begin
      out_wait = $urandom_range(0, 6);
      out_ready <= out_wait == 0;
    end else if (out_valid && out_ready) begin
      a.sx = out_clipped_start_x; a.sy = out_clipped_start_y;
      a.ex = out_clipped_end_x; a.ey = out_clipped_end_y; a.vis = out_visible;
      sb.check_result(a);
      out_wait = $urandom_range(0, 6);
      out_ready <= out_wait == 0;
    end else if (out_valid) begin
      if (out_wait == 0) out_ready <= 1'b1;
      else out_wait--;
    end
  end

  initial begin
    sb = new();
    sb.init_bounds();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_segment(0, 0, 100, 100, 0);
    send_segment(-20000000, 0, 20000000, 0, 0);
    send_segment(0, -20000000, 0, 20000000, 0);
    send_segment(-20000000, 3000000, 20000000, -3000000, 0);
    send_segment(0, 0, 20000000, 20000000, 0);
    send_segment(-20000000, 20000000, 0, 0, 0);
    send_segment(-20000000, -20000000, -10000000, 20000000, 0);
    send_segment(20000000, 20000000, 30000000, 10000000, 0);
    send_segment(-20000000, 8000000, 20000000, 8000000, 0);
    send_segment(CMIN, CMIN, CMAX, CMAX, 0);
    send_segment(CMAX, CMIN, CMIN, CMAX, 0);
    send_segment(CMIN, 0, CMAX, 1, 0);
    send_segment(-7000000, 6000000, 6000000, 7000000, 0);
    send_segment(6553600, 6553600, -6553600, -6553600, 0);
    send_segment(6553601, 0, 6553601, 100, 0);
    send_segment(-1, -1, -1, -1, 0);
    drain();

    set_window(-65536, 65536, -65536, 65536, 1);
    send_segment(CMIN, 5, CMAX, -5, 0);
    random_phase(150, 200000, 1);
    drain();

    set_window(CMIN, CMAX, CMIN, CMAX, 0);
    random_phase(80, 100000000, 1);
    drain();

    set_window(1000000, -1000000, 1000000, -1000000, -5);
    random_phase(80, 3000000, 1);
    drain();

    set_window(-300000, 500000, -200000, 400000, 3000);
    random_phase(250, 1500000, 1);
    drain();

    set_window(-6553600, 6553600, -6553600, 6553600, 0);
    random_phase(240, 20000000, 0);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== outcode_line_clipper_top.f =====
+incdir+rtl/core
rtl/core/olc_pkg.sv
rtl/core/olc_front.sv
rtl/core/olc_div.sv
rtl/core/olc_back.sv
rtl/core/outcode_line_clipper_top.sv
tb/tb_top.sv
